FILE: rtl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types and constants for the ordered key-value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

	// default number of table entries
	localparam int TABLE_DEPTH_DEF = 64;

	// operation codes on the op field
	typedef enum logic [2:0] {
		OP_PUT  = 3'd0,
		OP_GET  = 3'd1,
		OP_DEL  = 3'd2,
		OP_CLR  = 3'd3,
		OP_DUMP = 3'd4
	} op_e_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_BADOP = 2'd3
	} status_e_t;

	// source of the key/value fields of a result beat
	typedef enum logic [2:0] {
		SEL_REQ,   // request key and value
		SEL_KEY0,  // request key, zero value
		SEL_ZERO,  // zero key and value
		SEL_HIT,   // latched matching entry
		SEL_RD     // entry in the read register
	} sel_e_t;

	// memory write address/data source
	typedef enum logic [1:0] {
		WR_HIT,    // overwrite matching entry with request
		WR_APPEND, // write request at the fill position
		WR_SHIFT   // move read entry down by one slot
	} wr_e_t;

	// one stored entry
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
	} entry_t;

	// controller to datapath commands
	typedef struct packed {
		logic      ld_req;
		logic      adv;
		logic      ptr_clr;
		logic      hit_ld;
		logic      wr_en;
		wr_e_t     wr_sel;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      cnt_clr;
		logic      emit;
		sel_e_t    emit_sel;
		status_e_t emit_st;
		logic      emit_last;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic match;
		logic chk_last;
		logic cnt_zero;
		logic cnt_full;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/ordered_key_value_table_top.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table_top
// Insertion-ordered key-value table with put, get, delete, clear and dump.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_DEPTH 32-bit key/value pairs in one memory with
// a single registered read port, and that port sets the timing: a put, get or
// delete compares one stored entry per cycle and stops at the match, or at the
// last entry on a miss; an empty table skips the scan. A delete that hits then
// moves the later entries down one per cycle. Clear and an unknown op go
// straight to their result beat. A dump sends one result beat per entry, one
// per cycle while out_ready is high. A low out_ready holds back any result
// beat. A new command is taken only when the previous one has finished, while
// its last beat may still sit in the output register. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module ordered_key_value_table_top #(
	parameter int TABLE_DEPTH = okvt_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_key,
	output logic [31:0] out_value,
	output logic        last
);
	import okvt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	okvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and result path
	okvt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_key   (out_key),
		.out_value (out_value),
		.last      (last)
	);

endmodule

FILE: rtl/okvt_dp.sv
// ----------------------------------------------------------------------------
// okvt_dp
// Datapath: entry memory, scan pointer, entry count, request and hit
// registers, and the result output register.
// ----------------------------------------------------------------------------
module okvt_dp #(
	parameter int TABLE_DEPTH = okvt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  okvt_pkg::cmd_t       cmd,
	output okvt_pkg::sts_t       sts,
	input  logic [31:0]          key,
	input  logic [31:0]          value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [31:0]          out_key,
	output logic [31:0]          out_value,
	output logic                 last
);
	import okvt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	entry_t             mem [TABLE_DEPTH];
	entry_t             rd_data_q;
	entry_t             hit_q;
	logic [31:0]        key_q;
	logic [31:0]        val_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   chk_q;
	logic [CNT_W-1:0]   count_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [31:0]        out_key_q;
	logic [31:0]        out_value_q;
	logic               last_q;

	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic [31:0]        emit_key;
	logic [31:0]        emit_val;
	logic               out_free;

	// status toward the controller
	assign out_free     = !out_valid_q || out_ready;
	assign sts.match    = (rd_data_q.key == key_q);
	assign sts.chk_last = (CNT_W'(chk_q) == (count_q - CNT_W'(1)));
	assign sts.cnt_zero = (count_q == '0);
	assign sts.cnt_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign sts.out_free = out_free;

	// write port select
	always_comb begin
		wr_addr = chk_q;
		wr_data = '{key: key_q, value: val_q};
		unique case (cmd.wr_sel)
			WR_HIT: begin
				wr_addr = chk_q;
			end
			WR_APPEND: begin
				wr_addr = count_q[IDX_W-1:0];
			end
			WR_SHIFT: begin
				wr_addr = chk_q - IDX_W'(1);
				wr_data = rd_data_q;
			end
			default: begin
				wr_addr = chk_q;
			end
		endcase
	end

	// entry memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.adv) begin
			rd_data_q <= mem[ptr_q];
		end
	end

	// request and hit payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			key_q <= key;
			val_q <= value;
		end
		if (cmd.hit_ld) begin
			hit_q <= rd_data_q;
		end
	end

	// scan pointer and checked index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			chk_q <= '0;
		end else begin
			if (cmd.adv) begin
				chk_q <= ptr_q;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.adv && (ptr_q != IDX_W'(TABLE_DEPTH - 1))) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// result field select
	always_comb begin
		emit_key = '0;
		emit_val = '0;
		unique case (cmd.emit_sel)
			SEL_REQ: begin
				emit_key = key_q;
				emit_val = val_q;
			end
			SEL_KEY0: begin
				emit_key = key_q;
			end
			SEL_ZERO: begin
				emit_key = '0;
			end
			SEL_HIT: begin
				emit_key = hit_q.key;
				emit_val = hit_q.value;
			end
			SEL_RD: begin
				emit_key = rd_data_q.key;
				emit_val = rd_data_q.value;
			end
			default: begin
				emit_key = '0;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q    <= cmd.emit_st;
			out_key_q   <= emit_key;
			out_value_q <= emit_val;
			last_q      <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	// count stays within the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// append only into a table with room
	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.cnt_full)
		else $error("append into full table");

	// removal only from a non-empty table
	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !sts.cnt_zero)
		else $error("delete from empty table");

endmodule

FILE: rtl/okvt_ctrl.sv
// ----------------------------------------------------------------------------
// okvt_ctrl
// Controller: sequences scan, append, delete compaction, dump and result
// beats over the datapath.
// ----------------------------------------------------------------------------
module okvt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     op,
	input  okvt_pkg::sts_t sts,
	output okvt_pkg::cmd_t cmd
);
	import okvt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_SHIFT,
		S_DUMP,
		S_RESP
	} state_t;

	state_t      state_q, state_d;
	logic [2:0]  op_q;
	sel_e_t      resp_sel_q, resp_sel_d;
	status_e_t   resp_st_q, resp_st_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d       = state_q;
		resp_sel_d    = resp_sel_q;
		resp_st_d     = resp_st_q;
		cmd           = '0;
		cmd.wr_sel    = WR_HIT;
		cmd.emit_sel  = SEL_ZERO;
		cmd.emit_st   = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.ptr_clr = 1'b1;
				if (in_valid) begin
					cmd.ld_req = 1'b1;
					unique case (op)
						OP_PUT, OP_GET, OP_DEL: begin
							if (sts.cnt_zero) begin
								state_d = S_MISS;
							end else begin
								cmd.ptr_clr = 1'b0;
								cmd.adv     = 1'b1;
								state_d     = S_SCAN;
							end
						end
						OP_CLR: begin
							cmd.cnt_clr = 1'b1;
							resp_sel_d  = SEL_ZERO;
							resp_st_d   = ST_OK;
							state_d     = S_RESP;
						end
						OP_DUMP: begin
							if (sts.cnt_zero) begin
								resp_sel_d = SEL_ZERO;
								resp_st_d  = ST_MISS;
								state_d    = S_RESP;
							end else begin
								cmd.ptr_clr = 1'b0;
								cmd.adv     = 1'b1;
								state_d     = S_DUMP;
							end
						end
						default: begin
							resp_sel_d = SEL_ZERO;
							resp_st_d  = ST_BADOP;
							state_d    = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				// one entry compared per cycle
				cmd.adv = 1'b1;
				if (sts.match) begin
					cmd.hit_ld = 1'b1;
					resp_st_d  = ST_OK;
					unique case (op_q)
						OP_PUT: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_HIT;
							resp_sel_d = SEL_REQ;
							state_d    = S_RESP;
						end
						OP_DEL: begin
							resp_sel_d = SEL_HIT;
							if (sts.chk_last) begin
								cmd.cnt_dec = 1'b1;
								state_d     = S_RESP;
							end else begin
								state_d = S_SHIFT;
							end
						end
						default: begin
							resp_sel_d = SEL_HIT;
							state_d    = S_RESP;
						end
					endcase
				end else if (sts.chk_last) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				cmd.ptr_clr = 1'b1;
				state_d     = S_RESP;
				if (op_q == OP_PUT) begin
					resp_sel_d = SEL_REQ;
					if (sts.cnt_full) begin
						resp_st_d = ST_FULL;
					end else begin
						cmd.wr_en   = 1'b1;
						cmd.wr_sel  = WR_APPEND;
						cmd.cnt_inc = 1'b1;
						resp_st_d   = ST_OK;
					end
				end else begin
					resp_sel_d = SEL_KEY0;
					resp_st_d  = ST_MISS;
				end
			end
			S_SHIFT: begin
				// move later entries down one slot per cycle
				cmd.adv    = 1'b1;
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_SHIFT;
				if (sts.chk_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_DUMP: begin
				// one beat per entry, stepping when the output register frees
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = SEL_RD;
					cmd.emit_st   = ST_OK;
					cmd.emit_last = sts.chk_last;
					cmd.adv       = 1'b1;
					if (sts.chk_last) begin
						cmd.ptr_clr = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			S_RESP: begin
				cmd.ptr_clr = 1'b1;
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_sel  = resp_sel_q;
					cmd.emit_st   = resp_st_q;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= OP_PUT;
			resp_sel_q <= SEL_ZERO;
			resp_st_q  <= ST_OK;
		end else begin
			state_q    <= state_d;
			resp_sel_q <= resp_sel_d;
			resp_st_q  <= resp_st_d;
			if (state_q == S_IDLE && in_valid) begin
				op_q <= op;
			end
		end
	end

	// a beat is loaded only into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result beat overwrites pending beat");

	// every accepted command leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> (state_q != S_IDLE))
		else $error("accepted command not processed");

	// the count is decremented only by a delete
	a_dec_del: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (op_q == OP_DEL))
		else $error("count decrement outside delete");

endmodule

FILE: tb/tb_ordered_key_value_table_top.sv
// ----------------------------------------------------------------------------
// tb_ordered_key_value_table_top
// Self-checking bench for the insertion-ordered key-value table.
// ----------------------------------------------------------------------------
// A queue of commands feeds a clocked driver, and a clocked monitor drains the
// result port. Every accepted command runs through a shadow copy of the table
// kept in the bench, which queues the beats that the command should produce.
// Each result beat is checked field by field against the oldest of them.
// Directed commands cover the empty table, key and value extremes, updates,
// deletes at the front and end, clear, dump and unknown ops. A full fill
// sequence exercises the table-full status, a middle delete and the longest
// dump. Random commands then draw keys mostly from a small pool, so that hits
// are common. Both sides stall at random, except in one quiet window.
// ----------------------------------------------------------------------------
module tb_ordered_key_value_table_top;

	localparam int DEPTH       = okvt_pkg::TABLE_DEPTH_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 300;

	// one command waiting to be sent; hold_for_drain waits for all results
	typedef struct {
		logic [2:0]  op;
		logic [31:0] key;
		logic [31:0] value;
		bit          hold_for_drain;
	} cmd_item_t;

	// one result beat the table should produce
	typedef struct {
		okvt_pkg::status_e_t status;
		logic [31:0]         key;
		logic [31:0]         value;
		logic                last;
	} result_beat_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [2:0]  op        = '0;
	logic [31:0] key       = '0;
	logic [31:0] value     = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] out_key;
	logic [31:0] out_value;
	logic        last;

	cmd_item_t    pending_cmds[$];
	result_beat_t expected_beats[$];

	// shadow table
	logic [31:0] shadow_key[DEPTH];
	logic [31:0] shadow_val[DEPTH];
	int          shadow_fill = 0;

	int beats_predicted = 0;
	int beats_checked   = 0;
	int cmds_sent       = 0;
	int errors          = 0;
	int stall_cycles    = 0;
	logic [31:0] key_pool[12];
	cmd_item_t   next_cmd;
	result_beat_t want;

	// no idling on either side in this window
	wire calm = (cmds_sent >= 140) && (cmds_sent < 200);

	ordered_key_value_table_top #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_key   (out_key),
		.out_value (out_value),
		.last      (last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void push_beat(okvt_pkg::status_e_t st, logic [31:0] k,
			logic [31:0] v, logic fin);
		result_beat_t b;
		b.status = st;
		b.key    = k;
		b.value  = v;
		b.last   = fin;
		expected_beats.push_back(b);
		beats_predicted++;
	endfunction

	// apply one command to the shadow table and queue its result beats
	function automatic void table_command(logic [2:0] c_op, logic [31:0] c_key,
			logic [31:0] c_val);
		int pos;
		int i;
		pos = -1;
		for (i = 0; i < shadow_fill; i++) begin
			if (pos < 0 && shadow_key[i] == c_key)
				pos = i;
		end
		case (c_op)
			okvt_pkg::OP_PUT: begin
				if (pos >= 0) begin
					shadow_val[pos] = c_val;
					push_beat(okvt_pkg::ST_OK, c_key, c_val, 1'b1);
				end else if (shadow_fill < DEPTH) begin
					shadow_key[shadow_fill] = c_key;
					shadow_val[shadow_fill] = c_val;
					shadow_fill++;
					push_beat(okvt_pkg::ST_OK, c_key, c_val, 1'b1);
				end else begin
					push_beat(okvt_pkg::ST_FULL, c_key, c_val, 1'b1);
				end
			end
			okvt_pkg::OP_GET: begin
				if (pos >= 0)
					push_beat(okvt_pkg::ST_OK, shadow_key[pos], shadow_val[pos], 1'b1);
				else
					push_beat(okvt_pkg::ST_MISS, c_key, '0, 1'b1);
			end
			okvt_pkg::OP_DEL: begin
				if (pos >= 0) begin
					push_beat(okvt_pkg::ST_OK, shadow_key[pos], shadow_val[pos], 1'b1);
					// close the gap, keeping order
					for (i = pos; i < shadow_fill - 1; i++) begin
						shadow_key[i] = shadow_key[i + 1];
						shadow_val[i] = shadow_val[i + 1];
					end
					shadow_fill--;
				end else begin
					push_beat(okvt_pkg::ST_MISS, c_key, '0, 1'b1);
				end
			end
			okvt_pkg::OP_CLR: begin
				shadow_fill = 0;
				push_beat(okvt_pkg::ST_OK, '0, '0, 1'b1);
			end
			okvt_pkg::OP_DUMP: begin
				if (shadow_fill == 0)
					push_beat(okvt_pkg::ST_MISS, '0, '0, 1'b1);
				for (i = 0; i < shadow_fill; i++)
					push_beat(okvt_pkg::ST_OK, shadow_key[i], shadow_val[i],
						i == shadow_fill - 1);
			end
			default: begin
				push_beat(okvt_pkg::ST_BADOP, '0, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void add_cmd(logic [2:0] c_op, logic [31:0] c_key,
			logic [31:0] c_val, bit drain);
		cmd_item_t c;
		c.op             = c_op;
		c.key            = c_key;
		c.value          = c_val;
		c.hold_for_drain = drain;
		pending_cmds.push_back(c);
	endfunction

	// random commands; keys mostly from the pool so that hits are common
	function automatic void add_random_cmds(int count);
		int roll;
		logic [2:0]  c_op;
		logic [31:0] c_key;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 35)
				c_op = okvt_pkg::OP_PUT;
			else if (roll < 55)
				c_op = okvt_pkg::OP_GET;
			else if (roll < 75)
				c_op = okvt_pkg::OP_DEL;
			else if (roll < 80)
				c_op = okvt_pkg::OP_CLR;
			else if (roll < 90)
				c_op = okvt_pkg::OP_DUMP;
			else
				c_op = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 99) < 85)
				c_key = key_pool[$urandom_range(0, 11)];
			else
				c_key = $urandom;
			// one pause for a full drain partway through
			add_cmd(c_op, c_key, $urandom, n == count / 2);
		end
	endfunction

	// fill to capacity, overflow, then edit and dump the full table
	function automatic void add_fill_sequence();
		logic [31:0] base;
		base = $urandom;
		add_cmd(okvt_pkg::OP_CLR, $urandom, $urandom, 1'b1);
		for (int i = 0; i < DEPTH; i++)
			add_cmd(okvt_pkg::OP_PUT, base ^ i, $urandom, 1'b0);
		for (int j = 0; j < 3; j++)
			add_cmd(okvt_pkg::OP_PUT, base ^ (DEPTH + j), $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, base ^ 5, $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_GET, base ^ (DEPTH - 1), $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_DUMP, $urandom, $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, base, $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, base ^ (DEPTH + 7), $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, base ^ (DEPTH + 8), $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, base ^ (DEPTH - 1), $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, base ^ 30, $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, base ^ (DEPTH + 7), $urandom, 1'b0);
		add_cmd(3'($urandom_range(5, 7)), $urandom, $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_DUMP, $urandom, $urandom, 1'b0);
		add_cmd(okvt_pkg::OP_CLR, $urandom, $urandom, 1'b0);
	endfunction

	// command driver: one beat per handshake, valid held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op       <= '0;
			key      <= '0;
			value    <= '0;
		end else begin
			if (in_valid && in_ready) begin
				table_command(op, key, value);
				cmds_sent <= cmds_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0
						&& !(pending_cmds[0].hold_for_drain
							&& beats_predicted != beats_checked)
						&& (calm || $urandom_range(0, 99) >= 20)) begin
					next_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					op       <= next_cmd.op;
					key      <= next_cmd.key;
					value    <= next_cmd.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				beats_checked <= beats_checked + 1;
				if (expected_beats.size() == 0) begin
					$display("%0t: unexpected beat status=%h key=%h value=%h last=%b",
						$time, status, out_key, out_value, last);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %h actual %h", $time,
							want.status, status);
						errors++;
					end
					if (out_key !== want.key) begin
						$display("%0t: out_key expected %h actual %h", $time,
							want.key, out_key);
						errors++;
					end
					if (out_value !== want.value) begin
						$display("%0t: out_value expected %h actual %h", $time,
							want.value, out_value);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %b actual %b", $time,
							want.last, last);
						errors++;
					end
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 20);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 12; i++)
			key_pool[i] = $urandom;

		// directed: empty table, extremes, update, deletes, bad ops, clear
		add_cmd(okvt_pkg::OP_DUMP, '0, '0, 1'b0);
		add_cmd(okvt_pkg::OP_GET, '0, '1, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, '1, '0, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, '0, '0, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, '1, '1, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, '0, 32'ha5a5a5a5, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, 32'h12345678, 32'h5a5a5a5a, 1'b0);
		add_cmd(okvt_pkg::OP_GET, '0, '0, 1'b0);
		add_cmd(okvt_pkg::OP_GET, '1, '0, 1'b0);
		add_cmd(okvt_pkg::OP_GET, 32'h87654321, '0, 1'b0);
		add_cmd(okvt_pkg::OP_DUMP, '0, '0, 1'b0);
		add_cmd(3'd5, '1, '1, 1'b0);
		add_cmd(3'd6, 32'h0000ffff, '0, 1'b0);
		add_cmd(3'd7, '0, 32'hffff0000, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, '0, '0, 1'b0);
		add_cmd(okvt_pkg::OP_DUMP, '0, '0, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, 32'h12345678, '0, 1'b0);
		add_cmd(okvt_pkg::OP_DEL, '1, '0, 1'b0);
		add_cmd(okvt_pkg::OP_DUMP, '1, '1, 1'b0);
		add_cmd(okvt_pkg::OP_PUT, 32'd1, 32'd2, 1'b0);
		add_cmd(okvt_pkg::OP_CLR, '1, '1, 1'b0);
		add_cmd(okvt_pkg::OP_DUMP, '0, '0, 1'b0);
		add_cmd(okvt_pkg::OP_GET, 32'd1, '0, 1'b0);

		add_random_cmds(80);
		add_fill_sequence();
		add_random_cmds(90);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all commands sent and all results back, then a tail
		while (pending_cmds.size() != 0 || in_valid || beats_checked != beats_predicted)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_beats.size() != 0)
			$display("%0t: %0d expected beats never arrived", $time,
				expected_beats.size());
		if (errors == 0 && expected_beats.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/okvt_pkg.sv
rtl/okvt_dp.sv
rtl/okvt_ctrl.sv
rtl/ordered_key_value_table_top.sv
tb/tb_ordered_key_value_table_top.sv
